>>> src/nrlm_pkg.sv
// Shared types and codes for the linear-NFA longest-match block.
// No dependencies; used by nrlm_cell, nfa_regex_longest_match and nrlm_checker.
package nrlm_pkg;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_CHAR = 2'd1,
        FUNC_END  = 2'd2
    } func_t;

    // Per-request controls broadcast to every cell of the chain
    typedef struct packed {
        logic load;     // load a class word and flags
        logic advance;  // consume one text character
        logic restart;  // end of text, return to state 0
    } cell_ctrl_t;

    // Width of the fixed report field
    localparam int END_BITS = 32;

endpackage

>>> src/nrlm_cell.sv
// One NFA state: class bitmap, skip/repeat flags and the active bit.
// Chained to its neighbors through the skip carry and the advance token.
// Depends on nrlm_pkg.
module nrlm_cell #(
    parameter int INDEX      = 0,
    parameter int MAX_STATES = 16,
    parameter int CHAR_BITS  = 8,
    parameter int NW         = $clog2(MAX_STATES + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nrlm_pkg::cell_ctrl_t      ctrl,
    input  logic [NW-1:0]             n_states,
    input  logic [3:0]                state_index,
    input  logic [1:0]                word_index,
    input  logic [63:0]               class_word,
    input  logic                      skippable,
    input  logic                      repeatable,
    input  logic [CHAR_BITS-1:0]      ch_idx,
    input  logic                      carry_in,
    input  logic                      adv_in,
    output logic                      carry_out,
    output logic                      adv_out,
    output logic                      hit
);

    localparam int  ClassBits = 2 ** CHAR_BITS;
    localparam int  Words     = ClassBits / 64;
    localparam bit  Loadable  = (INDEX < MAX_STATES) && (INDEX < 16);

    logic [ClassBits-1:0] class_reg;
    logic                 skip_reg;
    logic                 rep_reg;
    logic                 active_reg;
    logic                 active_next;

    logic                 in_span;
    logic                 closed;
    logic                 match;
    logic                 load_here;
    logic [1:0]           word_sel;

    // Position of this cell relative to the accept index
    assign in_span = (32'(n_states) > INDEX);
    assign hit     = closed && (32'(n_states) == INDEX);

    // Skip closure: active here or reached by skipping the left neighbor
    assign closed    = active_reg | carry_in;
    assign match     = class_reg[ch_idx];
    assign carry_out = closed & skip_reg & in_span;
    assign adv_out   = closed & match & in_span;

    // Load decode; word index wraps to the bitmap size
    assign load_here = Loadable && ctrl.load && (32'(state_index) == INDEX);
    assign word_sel  = word_index & 2'(Words - 1);

    // Class bitmap and flags, no reset
    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            for (int w = 0; w < Words; w++)
            begin
                if (32'(word_sel) == w)
                begin
                    class_reg[w*64 +: 64] <= class_word;
                end
            end
            skip_reg <= skippable;
            rep_reg  <= repeatable;
        end
    end

    // Next active bit
    always_comb
    begin
        active_next = active_reg;
        if (ctrl.restart)
        begin
            active_next = (INDEX == 0) ? 1'b1 : 1'b0;
        end
        else if (ctrl.advance)
        begin
            active_next = adv_in | (closed & match & rep_reg & in_span);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= (INDEX == 0) ? 1'b1 : 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

>>> src/nfa_regex_longest_match.sv
// Longest-prefix matcher for a linear regex NFA, built as a chain of state cells.
// Depends on nrlm_pkg and nrlm_cell.
//
// Usage:
//   Input channel (in_valid/in_stall): one request per accepted cycle.
//     func LOAD writes one 64-bit class word plus the skip/repeat flags of a
//     state; func CHAR feeds one text character; func END closes the text.
//   Output channel (out_valid/out_stall): one result per END request,
//     matched plus end_position (start_offset + best length, saturating).
//   Config channel (cfg_valid/cfg_ready): writes pattern_states; ready is
//     always high. Write it only while no request is in flight.
// Latency and throughput:
//   One request per cycle for every func while in_stall is low; the closure
//   and advance ripple combinationally through all MAX_STATES+1 cells. An END
//   result is shown in the cycle after its request is accepted.
// Stall behavior:
//   A waiting result sits in the output register. LOAD and CHAR requests are
//   still taken; only an END request is held while that register is full
//   and stalled.
// Reset: only state 0 active, no match recorded, zero characters seen,
//   pattern_states zero, no result pending. Class data is not cleared.
module nfa_regex_longest_match #(
    parameter int MAX_STATES  = 16,
    parameter int CHAR_BITS   = 8,
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Config channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  state_index,
    input  logic [1:0]  word_index,
    input  logic [63:0] class_word,
    input  logic        skippable,
    input  logic        repeatable,
    input  logic [7:0]  character,
    input  logic [31:0] start_offset,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        matched,
    output logic [31:0] end_position
);

    localparam int NW = $clog2(MAX_STATES + 1);
    localparam int EB = nrlm_pkg::END_BITS;
    localparam int SW = ((LENGTH_BITS > EB) ? LENGTH_BITS : EB) + 1;

    logic [4:0]              pattern_states_reg;
    logic [LENGTH_BITS-1:0]  chars_seen_reg;
    logic [LENGTH_BITS-1:0]  chars_seen_next;
    logic [LENGTH_BITS-1:0]  best_length_reg;
    logic [LENGTH_BITS-1:0]  best_length_next;
    logic                    best_valid_reg;
    logic                    best_valid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    matched_reg;
    logic [EB-1:0]           end_position_reg;

    logic                    accept;
    logic                    is_load;
    logic                    is_char;
    logic                    is_end;
    nrlm_pkg::cell_ctrl_t    ctrl;
    logic [NW-1:0]           n_states;
    logic [CHAR_BITS-1:0]    ch_idx;
    logic [MAX_STATES+1:0]   carry;
    logic [MAX_STATES+1:0]   adv;
    logic [MAX_STATES:0]     hit;
    logic                    accept_hit;
    logic                    final_valid;
    logic [LENGTH_BITS-1:0]  final_len;
    logic [SW-1:0]           end_sum;
    logic [EB-1:0]           end_value;

    // Request decode
    assign is_load  = (func == 2'(nrlm_pkg::FUNC_LOAD));
    assign is_char  = (func == 2'(nrlm_pkg::FUNC_CHAR));
    assign is_end   = (func == 2'(nrlm_pkg::FUNC_END));
    assign in_stall = is_end & out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign ctrl.load    = accept & is_load;
    assign ctrl.advance = accept & is_char;
    assign ctrl.restart = accept & is_end;

    // Effective state count, clamped to the chain length
    assign n_states = (32'(pattern_states_reg) > MAX_STATES) ? NW'(MAX_STATES)
                                                              : NW'(pattern_states_reg);
    assign ch_idx   = CHAR_BITS'(character);

    // Cell chain; the cell at index MAX_STATES can only be the accept state
    assign carry[0] = 1'b0;
    assign adv[0]   = 1'b0;

    for (genvar i = 0; i <= MAX_STATES; i++)
    begin : g_cell
        nrlm_cell #(
            .INDEX      (i),
            .MAX_STATES (MAX_STATES),
            .CHAR_BITS  (CHAR_BITS),
            .NW         (NW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .n_states    (n_states),
            .state_index (state_index),
            .word_index  (word_index),
            .class_word  (class_word),
            .skippable   (skippable),
            .repeatable  (repeatable),
            .ch_idx      (ch_idx),
            .carry_in    (carry[i]),
            .adv_in      (adv[i]),
            .carry_out   (carry[i+1]),
            .adv_out     (adv[i+1]),
            .hit         (hit[i])
        );
    end

    assign accept_hit = |hit;

    // Run bookkeeping; lengths only grow, so a hit always records chars seen
    always_comb
    begin
        chars_seen_next  = chars_seen_reg;
        best_length_next = best_length_reg;
        best_valid_next  = best_valid_reg;
        if (ctrl.restart)
        begin
            chars_seen_next  = '0;
            best_length_next = '0;
            best_valid_next  = 1'b0;
        end
        else if (ctrl.advance)
        begin
            if (accept_hit)
            begin
                best_length_next = chars_seen_reg;
                best_valid_next  = 1'b1;
            end
            if (chars_seen_reg != '1)
            begin
                chars_seen_next = chars_seen_reg + 1'b1;
            end
        end
    end

    // Final report value, saturating at the field width
    assign final_valid = best_valid_reg | accept_hit;
    assign final_len   = accept_hit ? chars_seen_reg : best_length_reg;
    assign end_sum     = SW'(start_offset) + SW'(final_len);

    always_comb
    begin
        end_value = '0;
        if (final_valid)
        begin
            end_value = (end_sum > SW'({EB{1'b1}})) ? {EB{1'b1}} : end_sum[EB-1:0];
        end
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.restart)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_states_reg <= '0;
            chars_seen_reg     <= '0;
            best_length_reg    <= '0;
            best_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pattern_states_reg <= cfg_data;
            end
            chars_seen_reg  <= chars_seen_next;
            best_length_reg <= best_length_next;
            best_valid_reg  <= best_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.restart)
        begin
            matched_reg      <= final_valid;
            end_position_reg <= end_value;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign end_position = end_position_reg;

endmodule

>>> src/nrlm_checker.sv
// Port-level checks for nfa_regex_longest_match, attached with bind.
// Depends on nrlm_pkg.
module nrlm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  func,
    input logic        out_valid,
    input logic        out_stall,
    input logic        matched,
    input logic [31:0] end_position
);

    // A held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(matched) && $stable(end_position))
        else $error("result changed while stalled");

    // No match reports position zero
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> end_position == 32'd0)
        else $error("end_position nonzero without match");

    // A new result follows an accepted end-of-text request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && !in_stall && func == 2'(nrlm_pkg::FUNC_END)))
        else $error("result without end-of-text request");

    // Input is held back only by a stalled pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && func == 2'(nrlm_pkg::FUNC_END))
        else $error("input stalled without cause");

endmodule

bind nfa_regex_longest_match nrlm_checker u_nrlm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .matched      (matched),
    .end_position (end_position)
);
